// ===== src/sha_pkg.sv =====
// Package: SHA-256 constants, types and round functions shared by the engine modules.
package sha_pkg;

  localparam int unsigned LenBits = 64;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } in_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACK,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_EMIT
  } core_state_e;

  typedef logic [31:0] word_t;

  function automatic word_t init_h(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== src/sha_fifo.sv =====
// Two-entry input queue between the stream port and the hash core.
module sha_fifo
  import sha_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  in_item_t wr_item_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output in_item_t rd_item_o
);

  in_item_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push = wr_valid_i & wr_ready_o;
  assign pop  = rd_valid_o & rd_ready_i;
  assign rd_item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/sha_core.sv =====
// Hash core: byte packing, padding, one compression round per cycle and digest output.
module sha_core
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_o,
  output logic [2:0]  index_o,
  output logic        last_o
);

  core_state_e state_q, state_d;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic [2:0]  bcnt_q;   // bytes of the current word left to pack
  logic [1:0]  bidx_q;   // byte position within the held word
  word_t       word_q;
  logic        last_q;
  logic        fin_q;    // padding phase active
  logic        lenph_q;  // writing length bytes
  logic [3:0]  pcnt_q;   // padding byte counter for length
  logic [2:0]  oidx_q;

  // byte that goes into the buffer this cycle
  logic [7:0]  byte_v;
  logic [63:0] len_v;
  word_t       wn, t1, t2, s_new;
  logic [3:0]  wi;

  // keep only the low LenBits bits of the message length
  assign len_v = bits_q & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - LenBits));
  always_comb begin
    byte_v = word_q[31 - 8*bidx_q -: 8];
    if (state_q == ST_PAD) begin
      if (!lenph_q) byte_v = fin_q ? 8'h00 : 8'h80;
      else byte_v = len_v[63 - 8*pcnt_q[2:0] -: 8];
    end
  end

  assign wi    = rnd_q[3:0];
  assign s_new = w_q[wi] + sig0(w_q[wi + 4'd1]) + w_q[wi + 4'd9] + sig1(w_q[wi + 4'd14]);
  assign wn    = (rnd_q < 6'd16) ? w_q[wi] : s_new;
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
              + RoundK[rnd_q] + wn;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign digest_o    = h_q[oidx_q];
  assign index_o     = oidx_q;
  assign last_o      = (oidx_q == 3'd7);

  logic pack_fire;
  assign pack_fire = (state_q == ST_PACK) || (state_q == ST_PAD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PACK;
      ST_PACK: begin
        if (bcnt_q == 3'd0) state_d = last_q ? ST_PAD : ST_IDLE;
        else if (fill_q == 6'd63) state_d = ST_COMP;
      end
      ST_PAD: if (fill_q == 6'd63) state_d = ST_COMP;
      ST_COMP: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (fin_q && lenph_q && pcnt_q == 4'd8) state_d = ST_EMIT;
        else if (fin_q) state_d = ST_PAD;
        else if (bcnt_q != 3'd0) state_d = ST_PACK;
        else state_d = last_q ? ST_PAD : ST_IDLE;
      end
      ST_EMIT: if (out_ready_i && oidx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pack_fire && !(state_q == ST_PACK && bcnt_q == 3'd0)) begin
      w_q[fill_q[5:2]][31 - 8*fill_q[1:0] -: 8] <= byte_v;
    end
    if (state_q == ST_COMP && rnd_q >= 6'd16) begin
      w_q[wi] <= s_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_h(3'(i));
        v_q[i] <= '0;
      end
      fill_q <= '0; bits_q <= '0; rnd_q <= '0; bcnt_q <= '0; bidx_q <= '0;
      word_q <= '0; last_q <= 1'b0; fin_q <= 1'b0; lenph_q <= 1'b0;
      pcnt_q <= '0; oidx_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: if (in_valid_i) begin
          word_q <= in_item_i.data;
          bcnt_q <= (in_item_i.nbytes > 3'd4) ? 3'd4 : in_item_i.nbytes;
          bidx_q <= '0;
          last_q <= in_item_i.last;
        end
        ST_PACK: if (bcnt_q != 3'd0) begin
          fill_q <= fill_q + 6'd1;
          bits_q <= bits_q + 64'd8;
          bcnt_q <= bcnt_q - 3'd1;
          bidx_q <= bidx_q + 2'd1;
        end
        ST_PAD: begin
          fill_q <= fill_q + 6'd1;
          fin_q  <= 1'b1;
          if (lenph_q) pcnt_q <= pcnt_q + 4'd1;
          if (fill_q == 6'd55) lenph_q <= 1'b1;
        end
        ST_COMP: begin
          if (rnd_q == 6'd0) begin
            // round 0 works from the hash state directly
            v_q[7] <= h_q[6]; v_q[6] <= h_q[5]; v_q[5] <= h_q[4];
            v_q[3] <= h_q[2]; v_q[2] <= h_q[1]; v_q[1] <= h_q[0];
          end else begin
            v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
            v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          end
          v_q[4] <= v_q[3] + t1;
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        ST_EMIT: if (out_ready_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
            fill_q <= '0; bits_q <= '0; fin_q <= 1'b0; lenph_q <= 1'b0;
            pcnt_q <= '0; last_q <= 1'b0;
          end
        end
        default: ;
      endcase
      // load working vars from hash state on entry to the rounds
      if (state_d == ST_COMP && state_q != ST_COMP) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
        rnd_q <= '0;
      end
    end
  end

endmodule

// ===== src/sha256_hash_engine.sv =====
// Top level: SHA-256 stream engine with an input queue in front of the hash core.
// A word passes through the queue and is packed into the block buffer byte by byte;
// each full 64-byte block then runs 64 compression rounds and an add step.
// After the last word, padding fills the block up to its end and each padded block is
// compressed likewise, then the eight digest words leave one per cycle while taken.
// Reset (rst_ni low, async) loads the initial hash.
module sha256_hash_engine
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] data_word, [34:32] valid_bytes, zero fill
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast_o
);

  in_item_t   wr_item, rd_item;
  logic       q_valid, q_ready;
  logic [31:0] dig;
  logic [2:0]  idx;

  assign wr_item.data   = s_axis_tdata_i[31:0];
  assign wr_item.nbytes = s_axis_tdata_i[34:32];
  assign wr_item.last   = s_axis_tlast_i;

  sha_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(s_axis_tvalid_i), .wr_ready_o(s_axis_tready_o), .wr_item_i(wr_item),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_item_o(rd_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(rd_item),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .digest_o(dig), .index_o(idx), .last_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, idx, dig};

endmodule

// ===== src/sha_checker.sv =====
// Port-level checker for the SHA-256 engine, bound to the top level.
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_i,
  input logic        m_axis_tlast_i
);

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (m_axis_tlast_i == (m_axis_tdata_i[34:32] == 3'd7)))
    else $error("tlast does not match word index");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tready_i && !m_axis_tlast_i) |=>
      (m_axis_tvalid_i && m_axis_tdata_i[34:32] == $past(m_axis_tdata_i[34:32]) + 3'd1))
    else $error("digest words not consecutive");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=> (m_axis_tvalid_i && $stable(m_axis_tdata_i)))
    else $error("stalled output changed");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (m_axis_tdata_i[39:35] == 5'd0))
    else $error("fill bits not zero");

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tlast_i(m_axis_tlast_o)
);
